// ----- hdl/lcrs_pkg.sv -----
// package for the link connect retry sequencer
// holds the phase encoding, register indexes, reset values and shared structs
// no dependencies

package lcrs_pkg;

  // widths of the item fields
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned NetW     = 3;
  localparam int unsigned AttW     = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned NetCntW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // padded stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // highest number of networks walked through
  localparam int unsigned MaxNetworks = 8;

  // event kinds carried in tuser
  localparam logic CmdBegin = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgSettingsValid = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNetworkCount  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAttempts      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeout       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRetryGap      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgInterval      = 3'd5;

  // phase codes as seen on the result
  localparam logic [PhaseW-1:0] CodeStarting  = 3'd0;
  localparam logic [PhaseW-1:0] CodeTrying    = 3'd1;
  localparam logic [PhaseW-1:0] CodeBetween   = 3'd2;
  localparam logic [PhaseW-1:0] CodeConnected = 3'd3;
  localparam logic [PhaseW-1:0] CodeStopped   = 3'd4;

  typedef enum logic [4:0] {
    PhStarting  = 5'b00001,
    PhTrying    = 5'b00010,
    PhBetween   = 5'b00100,
    PhConnected = 5'b01000,
    PhStopped   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                settings_valid;
    logic [NetCntW-1:0]  network_count;
    logic [AttW-1:0]     attempts_per_network;
    logic [TimeW-1:0]    attempt_timeout_ms;
    logic [TimeW-1:0]    retry_gap_ms;
    logic [TimeW-1:0]    upload_interval_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    settings_valid:       1'b1,
    network_count:        4'd1,
    attempts_per_network: 8'd3,
    attempt_timeout_ms:   32'd15000,
    retry_gap_ms:         32'd250,
    upload_interval_ms:   32'd600000
  };

  typedef struct packed {
    phase_e           phase;
    logic [NetW-1:0]  network_sel;
    logic [AttW-1:0]  attempt_count;
    logic [TimeW-1:0] phase_started;
    logic [TimeW-1:0] window_started;
  } state_t;

  typedef struct packed {
    logic             command;
    logic [TimeW-1:0] now_ms;
    logic             link_up;
  } event_t;

  typedef struct packed {
    logic             window_due;
    logic             time_sync_request;
    logic             disconnect_request;
    logic             connect_request;
    logic [AttW-1:0]  attempt_index;
    logic [NetW-1:0]  network_index;
    logic [PhaseW-1:0] phase;
  } result_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PhStarting:  code = CodeStarting;
      PhTrying:    code = CodeTrying;
      PhBetween:   code = CodeBetween;
      PhConnected: code = CodeConnected;
      default:     code = CodeStopped;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/lcrs_step.sv -----
// next-state and result logic for one event of the retry sequencer
// purely combinational; depends on lcrs_pkg

module lcrs_step (
  input  lcrs_pkg::cfg_t    cfg_i,
  input  lcrs_pkg::state_t  state_i,
  input  lcrs_pkg::event_t  event_i,
  output lcrs_pkg::state_t  state_o,
  output lcrs_pkg::result_t result_o
);

  logic [lcrs_pkg::TimeW-1:0]   phase_elapsed;
  logic [lcrs_pkg::TimeW-1:0]   window_elapsed;
  logic                         timeout_hit;
  logic                         gap_hit;
  logic                         window_hit;
  logic [lcrs_pkg::NetCntW-1:0] nets_eff;
  logic [lcrs_pkg::AttW-1:0]    tries_eff;
  logic                         attempt_more;
  logic                         net_more;
  logic                         connect;
  logic                         disconnect;
  logic                         sync;
  logic                         due;
  lcrs_pkg::state_t             nxt;

  // wrapping elapsed times
  assign phase_elapsed  = event_i.now_ms - state_i.phase_started;
  assign window_elapsed = event_i.now_ms - state_i.window_started;
  assign timeout_hit    = phase_elapsed >= cfg_i.attempt_timeout_ms;
  assign gap_hit        = phase_elapsed >= cfg_i.retry_gap_ms;
  assign window_hit     = window_elapsed >= cfg_i.upload_interval_ms;

  // clamp the network count and attempts to sensible ranges
  always_comb begin
    if (cfg_i.network_count == '0) begin
      nets_eff = lcrs_pkg::NetCntW'(1);
    end else if (cfg_i.network_count > lcrs_pkg::NetCntW'(lcrs_pkg::MaxNetworks)) begin
      nets_eff = lcrs_pkg::NetCntW'(lcrs_pkg::MaxNetworks);
    end else begin
      nets_eff = cfg_i.network_count;
    end
    tries_eff = (cfg_i.attempts_per_network == '0) ? lcrs_pkg::AttW'(1)
                                                   : cfg_i.attempts_per_network;
  end

  assign attempt_more = ({1'b0, state_i.attempt_count} + (lcrs_pkg::AttW+1)'(1))
                        < {1'b0, tries_eff};
  assign net_more     = ({1'b0, state_i.network_sel} + lcrs_pkg::NetCntW'(1)) < nets_eff;

  always_comb begin
    nxt        = state_i;
    connect    = 1'b0;
    disconnect = 1'b0;
    sync       = 1'b0;
    due        = 1'b0;
    if (event_i.command == lcrs_pkg::CmdBegin) begin
      nxt.window_started = event_i.now_ms;
      if (!cfg_i.settings_valid) begin
        nxt.phase = lcrs_pkg::PhStopped;
      end else begin
        nxt.network_sel   = '0;
        nxt.attempt_count = '0;
        nxt.phase         = lcrs_pkg::PhStarting;
        nxt.phase_started = event_i.now_ms;
      end
    end else begin
      case (state_i.phase)
        lcrs_pkg::PhStarting: begin
          connect           = 1'b1;
          nxt.phase         = lcrs_pkg::PhTrying;
          nxt.phase_started = event_i.now_ms;
        end
        lcrs_pkg::PhTrying: begin
          if (event_i.link_up) begin
            nxt.phase = lcrs_pkg::PhConnected;
            sync      = 1'b1;
          end else if (timeout_hit) begin
            disconnect = 1'b1;
            if (attempt_more) begin
              nxt.attempt_count = state_i.attempt_count + lcrs_pkg::AttW'(1);
              nxt.phase         = lcrs_pkg::PhBetween;
              nxt.phase_started = event_i.now_ms;
            end else if (net_more) begin
              nxt.network_sel   = state_i.network_sel + lcrs_pkg::NetW'(1);
              nxt.attempt_count = '0;
              nxt.phase         = lcrs_pkg::PhBetween;
              nxt.phase_started = event_i.now_ms;
            end else begin
              nxt.phase = lcrs_pkg::PhStopped;
            end
          end
        end
        lcrs_pkg::PhBetween: begin
          if (gap_hit) begin
            connect           = 1'b1;
            nxt.phase         = lcrs_pkg::PhTrying;
            nxt.phase_started = event_i.now_ms;
          end
        end
        lcrs_pkg::PhConnected: begin
          // link lost: start over from the first network
          if (!event_i.link_up) begin
            disconnect        = 1'b1;
            nxt.network_sel   = '0;
            nxt.attempt_count = '0;
            nxt.phase         = lcrs_pkg::PhBetween;
            nxt.phase_started = event_i.now_ms;
          end
        end
        default: begin
          nxt.phase = lcrs_pkg::PhStopped;
        end
      endcase
      if (window_hit) begin
        due                = 1'b1;
        nxt.window_started = event_i.now_ms;
      end
    end
  end

  assign state_o                     = nxt;
  assign result_o.phase              = lcrs_pkg::phase_code(nxt.phase);
  assign result_o.network_index      = nxt.network_sel;
  assign result_o.attempt_index      = nxt.attempt_count;
  assign result_o.connect_request    = connect;
  assign result_o.disconnect_request = disconnect;
  assign result_o.time_sync_request  = sync;
  assign result_o.window_due         = due;

endmodule

// ----- hdl/link_connect_retry_sequencer_core.sv -----
// Link connection retry sequencer. Begin and tick events come in on the slave stream, each
// with a millisecond timestamp and the link-up flag; every event gives exactly one result
// word with the phase, network and attempt indexes and the connect, disconnect, time sync and
// window-due flags. One event is taken per clock cycle unless the output stalls: an event is
// held in the input register, the sequencer step is evaluated from it and the state
// registers, and the result lands in the output register, from which it is offered on the
// result stream. The input only stalls while both registers are full and the result word is
// not taken. The sequencer state is updated as the result is registered, so the next event
// sees it at once. Registers must be written through the cfg port only while no event is in
// flight; the block itself does not enforce this.
// depends on lcrs_pkg and lcrs_step

module link_connect_retry_sequencer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // event stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lcrs_pkg::InDataW-1:0]    s_axis_tdata_i,  // now_ms[31:0], link_up[32], zero pad
  input  logic                            s_axis_tuser_i,  // command: 0 begin, 1 tick
  // result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // phase[2:0], network_index[5:3], attempt_index[13:6], connect_request[14],
  // disconnect_request[15], time_sync_request[16], window_due[17], zero pad
  output logic [lcrs_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcrs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lcrs_pkg::CfgDataW-1:0]   cfg_data_i
);

  lcrs_pkg::cfg_t    cfg_q;
  lcrs_pkg::state_t  state_q;
  lcrs_pkg::state_t  state_d;
  lcrs_pkg::event_t  event_q;
  lcrs_pkg::result_t result_d;
  lcrs_pkg::result_t result_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              advance;
  logic              in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lcrs_pkg::CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lcrs_pkg::CfgSettingsValid: cfg_q.settings_valid       <= cfg_data_i[0];
        lcrs_pkg::CfgNetworkCount:  cfg_q.network_count        <= cfg_data_i[lcrs_pkg::NetCntW-1:0];
        lcrs_pkg::CfgAttempts:      cfg_q.attempts_per_network <= cfg_data_i[lcrs_pkg::AttW-1:0];
        lcrs_pkg::CfgTimeout:       cfg_q.attempt_timeout_ms   <= cfg_data_i;
        lcrs_pkg::CfgRetryGap:      cfg_q.retry_gap_ms         <= cfg_data_i;
        lcrs_pkg::CfgInterval:      cfg_q.upload_interval_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step the held event when the result register is free or being drained
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_take || (in_vld_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      event_q.command <= s_axis_tuser_i;
      event_q.now_ms  <= s_axis_tdata_i[lcrs_pkg::TimeW-1:0];
      event_q.link_up <= s_axis_tdata_i[lcrs_pkg::TimeW];
    end
  end

  lcrs_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .event_i  (event_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= lcrs_pkg::PhStopped;
      state_q.network_sel    <= '0;
      state_q.attempt_count  <= '0;
      state_q.phase_started  <= '0;
      state_q.window_started <= '0;
      out_vld_q              <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      out_vld_q <= advance || (out_vld_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(lcrs_pkg::OutDataW - $bits(lcrs_pkg::result_t))'(0), result_q};

endmodule
